// ===== rtl/core/smre_pkg.sv =====
package smre_pkg;

   localparam int INNER_MAX_DEF   = 64;
   localparam int COLUMNS_MAX_DEF = 16;
   localparam int ROWS_LIMIT      = 1024;

   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 32;
   localparam int ACC_W       = 48;
   localparam int ROW_POS_W   = 10;
   localparam int ROW_CNT_W   = 11;
   localparam int INNER_FLD_W = 7;
   localparam int COLS_FLD_W  = 5;
   localparam int COL_IDX_W   = 4;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
   localparam logic [1:0] REG_INNER_SIZE   = 2'd1;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd2;

   typedef struct packed {
      logic advance;
      logic write;
      logic accumulate;
      logic row_end;
      logic clear;
   } lane_ctl_type;

endpackage

// ===== rtl/core/streaming_matmul_row_engine_top.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_cmd, req_element_value
// rsp     | out       | rsp_valid/rsp_ready  | result_value, column_index, last flags
// csr     | in        | APB psel/penable     | paddr, pwdata, prdata
//
// One request per cycle while req_ready is high; every column lane does its multiply-accumulate in parallel.
// A row of results enters the shift bank once its last left element has passed the v1 and v2 registers,
// then leaves one result per cycle while rsp_ready is high, column_count results in all.
// req_ready drops while a finished row waits for the bank still draining the previous one.
// Synchronous reset clears positions, flags and accumulators; the right store is not cleared.
module streaming_matmul_row_engine_top import smre_pkg::*; #(
   parameter int INNER_MAX   = INNER_MAX_DEF,
   parameter int COLUMNS_MAX = COLUMNS_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic signed [ELEM_W-1:0]     req_element_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ACC_W-1:0]      rsp_result_value,
   output logic [COL_IDX_W-1:0]         rsp_column_index,
   output logic                         rsp_last_of_row,
   output logic                         rsp_last_of_matrix,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int AW  = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
   localparam int IRW = $clog2(INNER_MAX + 1);
   localparam int CW  = (COLUMNS_MAX > 1) ? $clog2(COLUMNS_MAX) : 1;
   localparam int CRW = $clog2(COLUMNS_MAX + 1);

   logic [ROW_CNT_W-1:0] row_count_ff, row_count_in;
   logic [IRW-1:0]       inner_size_ff, inner_size_in;
   logic [CRW-1:0]       column_count_ff, column_count_in;

   logic [AW-1:0]        load_row_ff, load_row_in;
   logic [CW-1:0]        load_col_ff, load_col_in;
   logic                 loaded_ff, loaded_in;
   logic [AW-1:0]        inner_pos_ff, inner_pos_in;
   logic [ROW_POS_W-1:0] row_pos_ff, row_pos_in;

   logic                 v1_ff, v1_in, last1_ff, last1_in, lm1_ff, lm1_in;
   logic                 v2_ff, v2_in, last2_ff, last2_in, lm2_ff, lm2_in;
   logic signed [ELEM_W-1:0] x_s1_ff;

   logic                 bank_valid_ff, bank_valid_in;
   logic                 bank_lm_ff, bank_lm_in;
   logic [CW-1:0]        out_col_ff, out_col_in;
   logic signed [ACC_W-1:0] bank_ff [COLUMNS_MAX];
   logic signed [ACC_W-1:0] row_sum [COLUMNS_MAX];

   logic advance, accept, stream_ok, bank_load, rsp_fire, out_last;
   logic load_last_col, load_last_row, inner_last, row_last;
   logic cfg_write, cfg_clear;
   logic [1:0] cfg_index;
   logic [CW+COL_IDX_W-1:0] col_wide;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = csr_paddr[3:2];

   always_comb begin
      int unsigned raw;
      row_count_in    = row_count_ff;
      inner_size_in   = inner_size_ff;
      column_count_in = column_count_ff;
      cfg_clear       = 1'b0;
      raw             = 0;
      if (cfg_write) begin
         case (cfg_index)
            REG_ROW_COUNT: begin
               raw = 32'(csr_pwdata[ROW_CNT_W-1:0]);
               if (raw == 0) raw = 1;
               if (raw > ROWS_LIMIT) raw = ROWS_LIMIT;
               row_count_in = ROW_CNT_W'(raw);
               cfg_clear    = 1'b1;
            end
            REG_INNER_SIZE: begin
               raw = 32'(csr_pwdata[INNER_FLD_W-1:0]);
               if (raw == 0) raw = 1;
               if (raw > INNER_MAX) raw = INNER_MAX;
               inner_size_in = IRW'(raw);
               cfg_clear     = 1'b1;
            end
            REG_COLUMN_COUNT: begin
               raw = 32'(csr_pwdata[COLS_FLD_W-1:0]);
               if (raw == 0) raw = 1;
               if (raw > COLUMNS_MAX) raw = COLUMNS_MAX;
               column_count_in = CRW'(raw);
               cfg_clear       = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         REG_ROW_COUNT:    csr_prdata = CSR_DATA_W'(row_count_ff);
         REG_INNER_SIZE:   csr_prdata = CSR_DATA_W'(inner_size_ff);
         REG_COLUMN_COUNT: csr_prdata = CSR_DATA_W'(column_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign advance   = !(v2_ff && last2_ff && bank_valid_ff && !(rsp_fire && out_last));
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign stream_ok = accept && req_cmd && loaded_ff;
   assign bank_load = advance && v2_ff && last2_ff;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign load_last_col = CRW'(load_col_ff) + CRW'(1) == column_count_ff;
   assign load_last_row = IRW'(load_row_ff) + IRW'(1) == inner_size_ff;
   assign inner_last    = IRW'(inner_pos_ff) + IRW'(1) == inner_size_ff;
   assign row_last      = ({1'b0, row_pos_ff} + ROW_CNT_W'(1)) >= row_count_ff;
   assign out_last      = CRW'(out_col_ff) + CRW'(1) == column_count_ff;

   always_comb begin
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      loaded_in     = loaded_ff;
      inner_pos_in  = inner_pos_ff;
      row_pos_in    = row_pos_ff;
      if (accept && !req_cmd) begin
         if (load_row_ff == '0 && load_col_ff == '0) loaded_in = 1'b0;
         if (load_last_col) begin
            load_col_in = '0;
            if (load_last_row) begin
               load_row_in = '0;
               loaded_in   = 1'b1;
            end else begin
               load_row_in = load_row_ff + AW'(1);
            end
         end else begin
            load_col_in = load_col_ff + CW'(1);
         end
      end
      if (stream_ok) begin
         if (inner_last) begin
            inner_pos_in = '0;
            row_pos_in   = row_last ? '0 : row_pos_ff + ROW_POS_W'(1);
         end else begin
            inner_pos_in = inner_pos_ff + AW'(1);
         end
      end
      if (cfg_clear) begin
         load_row_in  = '0;
         load_col_in  = '0;
         loaded_in    = 1'b0;
         inner_pos_in = '0;
         row_pos_in   = '0;
      end
   end

   always_comb begin
      v1_in    = v1_ff;
      last1_in = last1_ff;
      lm1_in   = lm1_ff;
      v2_in    = v2_ff;
      last2_in = last2_ff;
      lm2_in   = lm2_ff;
      if (advance) begin
         v1_in    = stream_ok;
         last1_in = inner_last;
         lm1_in   = inner_last && row_last;
         v2_in    = v1_ff;
         last2_in = last1_ff;
         lm2_in   = lm1_ff;
      end
      if (cfg_clear) begin
         v1_in = 1'b0;
         v2_in = 1'b0;
      end
   end

   always_comb begin
      bank_valid_in = bank_valid_ff;
      bank_lm_in    = bank_lm_ff;
      out_col_in    = out_col_ff;
      if (rsp_fire) begin
         out_col_in = out_col_ff + CW'(1);
         if (out_last) bank_valid_in = 1'b0;
      end
      if (bank_load) begin
         bank_valid_in = 1'b1;
         bank_lm_in    = lm2_ff;
         out_col_in    = '0;
      end
      if (cfg_clear) bank_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_CNT_W'(1);
         inner_size_ff   <= IRW'(INNER_MAX);
         column_count_ff <= CRW'(COLUMNS_MAX);
         load_row_ff     <= '0;
         load_col_ff     <= '0;
         loaded_ff       <= 1'b0;
         inner_pos_ff    <= '0;
         row_pos_ff      <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         bank_valid_ff   <= 1'b0;
         out_col_ff      <= '0;
      end else begin
         row_count_ff    <= row_count_in;
         inner_size_ff   <= inner_size_in;
         column_count_ff <= column_count_in;
         load_row_ff     <= load_row_in;
         load_col_ff     <= load_col_in;
         loaded_ff       <= loaded_in;
         inner_pos_ff    <= inner_pos_in;
         row_pos_ff      <= row_pos_in;
         v1_ff           <= v1_in;
         v2_ff           <= v2_in;
         bank_valid_ff   <= bank_valid_in;
         out_col_ff      <= out_col_in;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff   <= last1_in;
      lm1_ff     <= lm1_in;
      last2_ff   <= last2_in;
      lm2_ff     <= lm2_in;
      bank_lm_ff <= bank_lm_in;
      if (advance) begin
         x_s1_ff <= req_element_value;
      end
      if (bank_load) begin
         for (int c = 0; c < COLUMNS_MAX; c++) begin
            bank_ff[c] <= row_sum[c];
         end
      end else if (rsp_fire) begin
         for (int c = 0; c < COLUMNS_MAX - 1; c++) begin
            bank_ff[c] <= bank_ff[c+1];
         end
      end
   end

   for (genvar c = 0; c < COLUMNS_MAX; c++) begin : g_lane
      lane_ctl_type lane_ctl;

      assign lane_ctl.advance    = advance;
      assign lane_ctl.write      = accept && !req_cmd && (load_col_ff == CW'(c));
      assign lane_ctl.accumulate = v2_ff;
      assign lane_ctl.row_end    = last2_ff;
      assign lane_ctl.clear      = cfg_clear;

      smre_lane #(
         .INNER_MAX(INNER_MAX)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .wr_addr(load_row_ff),
         .rd_addr(inner_pos_ff),
         .wr_data(req_element_value),
         .x_value(x_s1_ff),
         .row_sum(row_sum[c])
      );
   end

   assign col_wide           = {{COL_IDX_W{1'b0}}, out_col_ff};
   assign rsp_valid          = bank_valid_ff;
   assign rsp_result_value   = bank_ff[0];
   assign rsp_column_index   = col_wide[COL_IDX_W-1:0];
   assign rsp_last_of_row    = out_last;
   assign rsp_last_of_matrix = out_last && bank_lm_ff;

`ifndef SYNTHESIS
   a_row_reaches_bank: assert property (@(posedge clock) disable iff (reset)
      (bank_load && !cfg_clear) |=> rsp_valid)
      else $error("finished row did not reach the result bank");

   a_out_col_range: assert property (@(posedge clock) disable iff (reset)
      bank_valid_ff |-> (CRW'(out_col_ff) < column_count_ff))
      else $error("result column beyond column count");

   a_inner_range: assert property (@(posedge clock) disable iff (reset)
      IRW'(inner_pos_ff) < inner_size_ff)
      else $error("inner position beyond inner size");

   a_load_col_range: assert property (@(posedge clock) disable iff (reset)
      CRW'(load_col_ff) < column_count_ff)
      else $error("load column beyond column count");

   a_stall_holds_row: assert property (@(posedge clock) disable iff (reset)
      (!advance && !cfg_clear) |=> (v2_ff && last2_ff))
      else $error("stalled row end lost");
`endif

endmodule

// ===== rtl/core/smre_ram.sv =====
module smre_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/smre_lane.sv =====
module smre_lane import smre_pkg::*; #(
   parameter int INNER_MAX = INNER_MAX_DEF,
   localparam int AW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctl_type             ctl,
   input  logic [AW-1:0]            wr_addr,
   input  logic [AW-1:0]            rd_addr,
   input  logic signed [ELEM_W-1:0] wr_data,
   input  logic signed [ELEM_W-1:0] x_value,
   output logic signed [ACC_W-1:0]  row_sum
);

   logic [ELEM_W-1:0]        weight_raw;
   logic signed [ELEM_W-1:0] weight;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  sum;

   smre_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(INNER_MAX)
   ) u_store (
      .clock  (clock),
      .wr_en  (ctl.write),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ctl.advance),
      .rd_addr(rd_addr),
      .rd_data(weight_raw)
   );

   assign weight = weight_raw;
   assign sum    = acc_ff + ACC_W'(prod_ff);

   always_comb begin
      prod_in = ctl.advance ? PROD_W'(x_value) * PROD_W'(weight) : prod_ff;
      acc_in  = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.advance && ctl.accumulate) begin
         acc_in = ctl.row_end ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign row_sum = sum;

endmodule

// ===== tb/streaming_matmul_row_engine_top_tb.sv =====
`timescale 1ns / 1ps

module streaming_matmul_row_engine_top_tb;
   import smre_pkg::*;

   localparam logic       CMD_LOAD_RIGHT  = 1'b0;
   localparam logic       CMD_STREAM_LEFT = 1'b1;
   localparam logic [1:0] REG_UNMAPPED    = 2'd3;

   localparam int STORE_SLOTS     = INNER_MAX_DEF * COLUMNS_MAX_DEF;
   localparam int SETTLE_CYCLES   = 16;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_STRETCH    = 300;
   localparam int RANDOM_REQUESTS = 420;

   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

   typedef struct {
      logic signed [ACC_W-1:0] value;
      logic [COL_IDX_W-1:0]    column;
      logic                    last_row;
      logic                    last_matrix;
   } product_entry_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_cmd;
   logic signed [ELEM_W-1:0]     req_element_value;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [ACC_W-1:0]      rsp_result_value;
   logic [COL_IDX_W-1:0]         rsp_column_index;
   logic                         rsp_last_of_row;
   logic                         rsp_last_of_matrix;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [CSR_ADDR_W-1:0]        csr_paddr;
   logic [CSR_DATA_W-1:0]        csr_pwdata;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;

   // predictor state
   int unsigned             shape_rows;
   int unsigned             shape_inner;
   int unsigned             shape_cols;
   logic signed [ELEM_W-1:0] right_copy [STORE_SLOTS];
   logic signed [ACC_W-1:0]  col_sums [COLUMNS_MAX_DEF];
   int unsigned             load_slot;
   int unsigned             inner_step;
   int unsigned             row_step;
   bit                      right_ready;

   product_entry_type expected_products[$];
   int unsigned    error_count;
   int unsigned    counted_requests;
   bit             send_gaps_on;
   bit             rsp_gaps_on;
   int unsigned    hold_cycles;

   streaming_matmul_row_engine_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_value   (rsp_result_value),
      .rsp_column_index   (rsp_column_index),
      .rsp_last_of_row    (rsp_last_of_row),
      .rsp_last_of_matrix (rsp_last_of_matrix),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_mismatch(input string msg);
      error_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic int unsigned clamp_field(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void clear_progress();
      for (int c = 0; c < COLUMNS_MAX_DEF; c++) begin
         col_sums[c] = '0;
      end
      load_slot = 0;
      inner_step = 0;
      row_step = 0;
      right_ready = 1'b0;
   endfunction

   function automatic void reset_model();
      shape_rows = 1;
      shape_inner = INNER_MAX_DEF;
      shape_cols = COLUMNS_MAX_DEF;
      for (int i = 0; i < STORE_SLOTS; i++) begin
         right_copy[i] = '0;
      end
      clear_progress();
   endfunction

   function automatic void apply_register(input logic [1:0] index,
                                          input logic [CSR_DATA_W-1:0] value);
      bit mapped;
      mapped = 1'b1;
      case (index)
         REG_ROW_COUNT: begin
            shape_rows = clamp_field(32'(value[ROW_CNT_W-1:0]), ROWS_LIMIT);
         end
         REG_INNER_SIZE: begin
            shape_inner = clamp_field(32'(value[INNER_FLD_W-1:0]), INNER_MAX_DEF);
         end
         REG_COLUMN_COUNT: begin
            shape_cols = clamp_field(32'(value[COLS_FLD_W-1:0]), COLUMNS_MAX_DEF);
         end
         default: begin
            mapped = 1'b0;
         end
      endcase
      if (mapped) clear_progress();
   endfunction

   // returns 1 unless the request is dropped for want of a loaded right matrix
   function automatic bit predict_request(input logic cmd, input logic signed [ELEM_W-1:0] elem);
      int unsigned              total;
      int unsigned              slot;
      logic signed [PROD_W-1:0] prod;
      product_entry_type        entry;
      total = shape_inner * shape_cols;
      if (cmd == CMD_LOAD_RIGHT) begin
         if (load_slot == 0) right_ready = 1'b0;
         right_copy[load_slot] = elem;
         load_slot++;
         if (load_slot >= total) begin
            load_slot = 0;
            right_ready = 1'b1;
         end
         return 1'b1;
      end
      if (!right_ready) return 1'b0;
      for (int c = 0; c < shape_cols; c++) begin
         slot = inner_step * shape_cols + c;
         prod = PROD_W'(elem) * PROD_W'(right_copy[slot]);
         col_sums[c] = col_sums[c] + ACC_W'(prod);
      end
      inner_step++;
      if (inner_step < shape_inner) return 1'b1;
      inner_step = 0;
      for (int c = 0; c < shape_cols; c++) begin
         entry.value = col_sums[c];
         entry.column = COL_IDX_W'(c);
         entry.last_row = (c + 1 == shape_cols);
         entry.last_matrix = entry.last_row && (row_step + 1 >= shape_rows);
         expected_products.push_back(entry);
         col_sums[c] = '0;
      end
      row_step++;
      if (row_step >= shape_rows) row_step = 0;
      return 1'b1;
   endfunction

   function automatic logic signed [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 7))
         0: return ELEM_MAX;
         1: return ELEM_MIN;
         default: return ELEM_W'($urandom());
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_noise(input int unsigned field,
                                                       input int unsigned width);
      logic [CSR_DATA_W-1:0] field_mask;
      field_mask = (CSR_DATA_W'(1) << width) - 1;
      if ($urandom_range(0, 1) == 0) return CSR_DATA_W'(field);
      return ($urandom() & ~field_mask) | (CSR_DATA_W'(field) & field_mask);
   endfunction

   task automatic send_request(input logic cmd, input logic signed [ELEM_W-1:0] elem);
      int   gap;
      logic accepted;
      gap = send_gaps_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_element_value <= elem;
      do begin
         @(negedge clock);
         accepted = (req_ready === 1'b1);
         @(posedge clock);
      end while (!accepted);
      if (predict_request(cmd, elem)) counted_requests++;
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      logic done;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         done = (csr_pready === 1'b1);
         @(posedge clock);
      end while (!done);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      apply_register(index, value);
      @(posedge clock);
   endtask

   // hold the request side idle until every product row has left the block
   task automatic drain_engine();
      req_valid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_shape(input int unsigned rows, input int unsigned inner,
                            input int unsigned cols);
      drain_engine();
      write_register(REG_ROW_COUNT, with_noise(rows, ROW_CNT_W));
      write_register(REG_INNER_SIZE, with_noise(inner, INNER_FLD_W));
      write_register(REG_COLUMN_COUNT, with_noise(cols, COLS_FLD_W));
   endtask

   task automatic load_right(input bit all_min);
      repeat (shape_inner * shape_cols) begin
         send_request(CMD_LOAD_RIGHT, all_min ? ELEM_MIN : pick_element());
      end
   endtask

   task automatic finish_load();
      while (!right_ready) send_request(CMD_LOAD_RIGHT, pick_element());
   endtask

   task automatic stream_row(input bit all_min);
      repeat (shape_inner - inner_step) begin
         send_request(CMD_STREAM_LEFT, all_min ? ELEM_MIN : pick_element());
      end
   endtask

   task automatic test_reset_defaults();
      send_gaps_on = 1'b0;
      rsp_gaps_on = 1'b1;
      send_request(CMD_STREAM_LEFT, pick_element());
      load_right(1'b0);
      stream_row(1'b0);
      stream_row(1'b0);
   endtask

   task automatic test_signed_extremes();
      send_gaps_on = 1'b1;
      set_shape(2, 2, 2);
      send_request(CMD_LOAD_RIGHT, ELEM_MAX);
      send_request(CMD_LOAD_RIGHT, ELEM_MIN);
      send_request(CMD_LOAD_RIGHT, -16'sd1);
      send_request(CMD_LOAD_RIGHT, 16'sd1);
      send_request(CMD_STREAM_LEFT, ELEM_MIN);
      send_request(CMD_STREAM_LEFT, ELEM_MAX);
      send_request(CMD_STREAM_LEFT, ELEM_MAX);
      send_request(CMD_STREAM_LEFT, ELEM_MIN);
      send_request(CMD_STREAM_LEFT, ELEM_MIN);
      send_request(CMD_STREAM_LEFT, ELEM_MIN);
      send_request(CMD_STREAM_LEFT, 16'sd0);
      send_request(CMD_STREAM_LEFT, 16'sd0);
   endtask

   task automatic test_register_limits();
      drain_engine();
      write_register(REG_ROW_COUNT, 32'hFFFF_F800);
      write_register(REG_INNER_SIZE, 32'hFFFF_FF80);
      write_register(REG_COLUMN_COUNT, 32'hFFFF_FFE0);
      send_request(CMD_LOAD_RIGHT, pick_element());
      send_request(CMD_STREAM_LEFT, pick_element());
      send_request(CMD_STREAM_LEFT, pick_element());
   endtask

   task automatic test_unmapped_register();
      set_shape(3, 3, 2);
      load_right(1'b0);
      send_request(CMD_STREAM_LEFT, pick_element());
      send_request(CMD_STREAM_LEFT, pick_element());
      drain_engine();
      write_register(REG_UNMAPPED, $urandom());
      stream_row(1'b0);
      stream_row(1'b0);
   endtask

   task automatic test_partial_reload();
      set_shape(2, 2, 1);
      load_right(1'b0);
      send_request(CMD_STREAM_LEFT, pick_element());
      send_request(CMD_LOAD_RIGHT, pick_element());
      send_request(CMD_STREAM_LEFT, pick_element());
      send_request(CMD_LOAD_RIGHT, pick_element());
      send_request(CMD_STREAM_LEFT, pick_element());
   endtask

   task automatic test_large_shapes();
      send_gaps_on = 1'b0;
      set_shape(2047, 127, 1);
      load_right(1'b1);
      stream_row(1'b1);
      stream_row(1'b0);
      send_gaps_on = 1'b1;
      set_shape(1024, 1, 31);
      load_right(1'b0);
      repeat (5) stream_row(1'b0);
   endtask

   task automatic test_backpressure();
      set_shape(3, 1, 16);
      send_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      load_right(1'b0);
      hold_cycles = HOLD_STRETCH;
      repeat (40) stream_row(1'b0);
      drain_engine();
   endtask

   task automatic test_random_traffic();
      int unsigned start_count;
      int unsigned rows_v;
      int unsigned inner_v;
      int unsigned cols_v;
      int unsigned kind;
      int unsigned cut;
      start_count = counted_requests;
      while (counted_requests - start_count < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 9))
            0: rows_v = 0;
            1: rows_v = 2047;
            default: rows_v = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 15))
            0: inner_v = 0;
            1: inner_v = 64;
            2: inner_v = 127;
            default: inner_v = $urandom_range(1, 8);
         endcase
         cols_v = ($urandom_range(0, 15) == 0) ? 31 : $urandom_range(0, 16);
         if (inner_v >= 64) cols_v = $urandom_range(1, 2);
         set_shape(rows_v, inner_v, cols_v);
         send_gaps_on = $urandom_range(0, 1);
         rsp_gaps_on = $urandom_range(0, 1);
         if ($urandom_range(0, 3) == 0) send_request(CMD_STREAM_LEFT, pick_element());
         load_right(1'b0);
         repeat ($urandom_range(3, 10)) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               repeat ($urandom_range(1, 4)) begin
                  send_request(1'($urandom_range(0, 1)), ELEM_W'($urandom()));
               end
            end
            else if (kind == 1) begin
               cut = $urandom_range(1, shape_inner * shape_cols);
               repeat (cut) send_request(CMD_LOAD_RIGHT, pick_element());
               repeat ($urandom_range(1, 3)) send_request(CMD_STREAM_LEFT, pick_element());
            end
            else if (kind == 2) begin
               load_right(1'b0);
            end
            else begin
               stream_row(1'b0);
            end
            finish_load();
         end
      end
   endtask

   task automatic check_product();
      product_entry_type want;
      if (expected_products.size() == 0) begin
         note_mismatch($sformatf("unexpected result %0d column %0d",
                                 rsp_result_value, rsp_column_index));
         return;
      end
      want = expected_products.pop_front();
      if (rsp_result_value !== want.value) begin
         note_mismatch($sformatf("result_value got %0d want %0d",
                                 rsp_result_value, want.value));
      end
      if (rsp_column_index !== want.column) begin
         note_mismatch($sformatf("column_index got %0d want %0d",
                                 rsp_column_index, want.column));
      end
      if (rsp_last_of_row !== want.last_row) begin
         note_mismatch($sformatf("last_of_row got %b want %b column %0d",
                                 rsp_last_of_row, want.last_row, want.column));
      end
      if (rsp_last_of_matrix !== want.last_matrix) begin
         note_mismatch($sformatf("last_of_matrix got %b want %b column %0d",
                                 rsp_last_of_matrix, want.last_matrix, want.column));
      end
   endtask

   initial begin : result_receiver
      int unsigned wait_left;
      logic        taken;
      wait_left = 0;
      taken = 1'b0;
      forever begin
         @(posedge clock);
         if (taken) wait_left = rsp_gaps_on ? $urandom_range(0, 19) : 0;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end
         else if (wait_left > 0) begin
            wait_left--;
            rsp_ready <= 1'b0;
         end
         else begin
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
         taken = !reset && (rsp_valid === 1'b1) && (rsp_ready === 1'b1);
         if (taken) check_product();
      end
   end

   initial begin : stall_watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1) ||
             (csr_psel === 1'b1 && csr_penable === 1'b1)) begin
            idle_cycles = 0;
         end
         else begin
            idle_cycles++;
         end
      end
      $display("streaming_matmul_row_engine_top_tb failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      req_element_value = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      counted_requests = 0;
      send_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      hold_cycles = 0;
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_signed_extremes();
      test_register_limits();
      test_unmapped_register();
      test_partial_reload();
      test_large_shapes();
      test_backpressure();
      test_random_traffic();

      drain_engine();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_products.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", expected_products.size()));
      end
      if (error_count == 0) begin
         $display("streaming_matmul_row_engine_top_tb passed");
      end
      else begin
         $display("streaming_matmul_row_engine_top_tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/smre_pkg.sv
rtl/core/smre_ram.sv
rtl/core/smre_lane.sv
rtl/core/streaming_matmul_row_engine_top.sv
tb/streaming_matmul_row_engine_top_tb.sv
